@@ rtl/dmrc_pkg.sv @@
// shared types and constants of the direct-mapped result cache
`default_nettype none

package dmrc_pkg;

    localparam int KEY_W   = 64;
    localparam int MOVE_W  = 32;
    localparam int VAL_W   = 16;
    localparam int DEPTH_W = 8;
    localparam int BOUND_W = 2;
    localparam int AGE_W   = 8;
    localparam int KIND_W  = 2;

    // operation carried by an input item
    typedef enum logic [KIND_W-1:0] {
        KIND_PROBE = 2'd0,
        KIND_STORE = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NOP   = 2'd3
    } t_kind;

    // controller state: sweeping the table to zero, or serving items
    typedef enum logic {
        ST_SWEEP = 1'b0,
        ST_RUN   = 1'b1
    } t_state;

    // one table entry; an all-zero tag marks an empty slot
    typedef struct packed {
        logic [KEY_W-1:0]          tag;
        logic [MOVE_W-1:0]         move;
        logic signed [VAL_W-1:0]   score;
        logic signed [VAL_W-1:0]   eval;
        logic [DEPTH_W-1:0]        depth;
        logic [BOUND_W-1:0]        bound;
        logic [AGE_W-1:0]          age;
    } t_entry;

endpackage

`default_nettype wire

@@ rtl/dmrc_in_if.sv @@
// input item channel of the result cache
`default_nettype none

interface dmrc_in_if;
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [63:0]         key;
    logic [31:0]         move_word;
    logic signed [15:0]  score_in;
    logic signed [15:0]  eval_in;
    logic [7:0]          depth_in;
    logic [1:0]          bound_in;

    modport source (
        output valid, kind, key, move_word, score_in, eval_in, depth_in, bound_in,
        input  ready
    );

    modport sink (
        input  valid, kind, key, move_word, score_in, eval_in, depth_in, bound_in,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/dmrc_out_if.sv @@
// result item channel of the result cache
`default_nettype none

interface dmrc_out_if;
    logic                valid;
    logic                ready;
    logic                hit;
    logic                written;
    logic [31:0]         move_out;
    logic signed [15:0]  score_out;
    logic signed [15:0]  eval_out;
    logic [7:0]          depth_out;
    logic [1:0]          bound_out;

    modport source (
        output valid, hit, written, move_out, score_out, eval_out, depth_out, bound_out,
        input  ready
    );

    modport sink (
        input  valid, hit, written, move_out, score_out, eval_out, depth_out, bound_out,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/dmrc_table.sv @@
// entry memory: one write port, one registered read port
`default_nettype none

module dmrc_table #(
    parameter int INDEX_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_re,
    input  logic [INDEX_BITS-1:0]  i_raddr,
    output dmrc_pkg::t_entry       o_rdata,
    input  logic                   i_we,
    input  logic [INDEX_BITS-1:0]  i_waddr,
    input  dmrc_pkg::t_entry       i_wdata
);
    import dmrc_pkg::*;

    localparam int DEPTH = 1 << INDEX_BITS;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // write, and registered read of the old contents
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/direct_mapped_result_cache.sv @@
// direct-mapped result cache with depth-preferred replacement
// a taken item is held in the table-read stage registers, then in the output register
// throughput: one probe or store per cycle while the output is taken and input is not blocked;
// table read and write-back share one entry memory; a clear item blocks input while the table is swept to zero
// reset (synchronous, active low) starts the same sweep; input ready stays
// low until it ends, configuration writes are taken throughout
`default_nettype none

module direct_mapped_result_cache #(
    parameter int INDEX_BITS = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [dmrc_pkg::AGE_W-1:0] i_cfg_wdata,
    dmrc_in_if.sink                    i_in,
    dmrc_out_if.source                 o_out
);
    import dmrc_pkg::*;

    // controller
    t_state                  r_state, n_state;
    logic [INDEX_BITS-1:0]   r_sweep_idx, n_sweep_idx;
    logic [AGE_W-1:0]        r_age;

    // item waiting for its table read
    logic                    r_s1_valid;
    t_kind                   r_s1_kind;
    logic [KEY_W-1:0]        r_s1_key;
    logic [MOVE_W-1:0]       r_s1_move;
    logic signed [VAL_W-1:0] r_s1_score;
    logic signed [VAL_W-1:0] r_s1_eval;
    logic [DEPTH_W-1:0]      r_s1_depth;
    logic [BOUND_W-1:0]      r_s1_bound;

    // last entry written, forwarded over the read it overlaps
    logic                    r_fwd_valid;
    logic [INDEX_BITS-1:0]   r_fwd_idx;
    t_entry                  r_fwd_data;

    // output register
    logic                    r_out_valid;
    logic                    r_out_hit;
    logic                    r_out_written;
    logic [MOVE_W-1:0]       r_out_move;
    logic signed [VAL_W-1:0] r_out_score;
    logic signed [VAL_W-1:0] r_out_eval;
    logic [DEPTH_W-1:0]      r_out_depth;
    logic [BOUND_W-1:0]      r_out_bound;

    logic                    out_free;
    logic                    s1_adv;
    logic                    s1_clear;
    logic                    in_ready;
    logic                    accept;
    logic [INDEX_BITS-1:0]   s1_idx;
    t_entry                  rd_data;
    t_entry                  cur;
    t_entry                  new_entry;
    logic                    probe_hit;
    logic                    do_store;
    logic                    mem_we;
    logic [INDEX_BITS-1:0]   mem_waddr;
    t_entry                  mem_wdata;

    // handshake
    assign out_free = !r_out_valid || o_out.ready;
    assign s1_adv   = r_s1_valid && out_free;
    assign s1_clear = r_s1_valid && (r_s1_kind == KIND_CLEAR);
    assign in_ready = (r_state == ST_RUN) && !s1_clear && (!r_s1_valid || out_free);
    assign accept   = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    // entry memory
    dmrc_table #(
        .INDEX_BITS (INDEX_BITS)
    ) u_table (
        .i_clk   (i_clk),
        .i_re    (accept),
        .i_raddr (i_in.key[INDEX_BITS-1:0]),
        .o_rdata (rd_data),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata)
    );

    // current entry contents, with the previous write forwarded
    assign s1_idx = r_s1_key[INDEX_BITS-1:0];
    assign cur    = (r_fwd_valid && (r_fwd_idx == s1_idx)) ? r_fwd_data : rd_data;

    // probe match and replacement decision
    assign probe_hit = (r_s1_kind == KIND_PROBE) && (r_s1_key != '0) && (cur.tag == r_s1_key);
    assign do_store  = (r_s1_kind == KIND_STORE) &&
                       ((cur.tag == '0) || (cur.tag == r_s1_key) ||
                        (r_s1_depth >= cur.depth) || (cur.age != r_age));

    // entry built from a store item
    always_comb begin
        new_entry       = '0;
        new_entry.tag   = r_s1_key;
        new_entry.move  = r_s1_move;
        new_entry.score = r_s1_score;
        new_entry.eval  = r_s1_eval;
        new_entry.depth = r_s1_depth;
        new_entry.bound = r_s1_bound;
        new_entry.age   = r_age;
    end

    // memory write: sweep zeros, or write a store's new entry over its slot
    always_comb begin
        if (r_state == ST_SWEEP) begin
            mem_we    = 1'b1;
            mem_waddr = r_sweep_idx;
            mem_wdata = '0;
        end else begin
            mem_we    = s1_adv && do_store;
            mem_waddr = s1_idx;
            mem_wdata = new_entry;
        end
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_sweep_idx = r_sweep_idx;
        case (r_state)
            ST_SWEEP: begin
                n_sweep_idx = r_sweep_idx + INDEX_BITS'(1);
                if (r_sweep_idx == '1) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (s1_adv && s1_clear) begin
                    n_state     = ST_SWEEP;
                    n_sweep_idx = '0;
                end
            end
            default: begin
                n_state     = ST_SWEEP;
                n_sweep_idx = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_sweep_idx <= '0;
            r_age       <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep_idx <= n_sweep_idx;
            if (s1_adv && s1_clear) begin
                r_age <= '0;
            end
            if (i_cfg_we) begin
                r_age <= i_cfg_wdata;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv && s1_clear) begin
                r_fwd_valid <= 1'b0;
            end else if (s1_adv && do_store) begin
                r_fwd_valid <= 1'b1;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind  <= t_kind'(i_in.kind);
            r_s1_key   <= i_in.key;
            r_s1_move  <= i_in.move_word;
            r_s1_score <= i_in.score_in;
            r_s1_eval  <= i_in.eval_in;
            r_s1_depth <= i_in.depth_in;
            r_s1_bound <= i_in.bound_in;
        end
        if (s1_adv && do_store) begin
            r_fwd_idx  <= s1_idx;
            r_fwd_data <= new_entry;
        end
        if (s1_adv) begin
            r_out_hit     <= probe_hit;
            r_out_written <= do_store;
            r_out_move    <= probe_hit ? cur.move  : '0;
            r_out_score   <= probe_hit ? cur.score : '0;
            r_out_eval    <= probe_hit ? cur.eval  : '0;
            r_out_depth   <= probe_hit ? cur.depth : '0;
            r_out_bound   <= probe_hit ? cur.bound : '0;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.hit       = r_out_hit;
    assign o_out.written   = r_out_written;
    assign o_out.move_out  = r_out_move;
    assign o_out.score_out = r_out_score;
    assign o_out.eval_out  = r_out_eval;
    assign o_out.depth_out = r_out_depth;
    assign o_out.bound_out = r_out_bound;

endmodule

`default_nettype wire
